// ----- rtl/core/sce_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sce_pkg
// Shared types, constants and helpers for the slab centroid extremes block.
// ---------------------------------------------------------------------------
package sce_pkg;

    localparam int COORD_W        = 32;
    localparam int CFG_W          = 5;
    localparam int CNT_MAX_W      = 17;      // holds a point count up to 65536
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_SLABS_DEF  = 16;

    localparam logic [CFG_W-1:0] SLAB_CFG_RESET = 5'd8;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   final_point;
    } point_in_t;

    typedef struct packed {
        coord_t lx;
        coord_t ly;
        coord_t lz;
        logic   run_end;
    } result_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Everything the back end needs about one finished load
    typedef struct packed {
        coord_t                 min_x;
        coord_t                 max_x;
        coord_t                 min_y;
        coord_t                 max_y;
        coord_t                 min_z;
        coord_t                 max_z;
        point_t                 left;
        point_t                 right;
        logic [CNT_MAX_W-1:0]   count;
        logic [CFG_W-1:0]       slab_cfg;
    } run_desc_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EDGE_START,
        B_EDGE_WAIT,
        B_SCAN_RD,
        B_SCAN_WAIT,
        B_SCAN_CLS,
        B_SCAN_ACC,
        B_EMIT_LEFT,
        B_SLAB_CHECK,
        B_DIV_START,
        B_DIV_WAIT,
        B_EMIT_CENT,
        B_EMIT_RIGHT
    } back_state_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/core/sce_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sce_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sce_divider #(
    parameter int DW = 43,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] div_reg, div_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/sce_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sce_queue
// Two-entry queue of run descriptors between the front and back ends.
// ---------------------------------------------------------------------------
module sce_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sce_pkg::run_desc_t push_data,
    output logic              full,
    input  logic              pop,
    output sce_pkg::run_desc_t pop_data,
    output logic              empty
);

    sce_pkg::run_desc_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/sce_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sce_front
// Point loader: stores points, tracks the bounding box and the X extremes,
// and hands a run descriptor to the queue on the final point.
// ---------------------------------------------------------------------------
module sce_front #(
    parameter int MAX_POINTS = sce_pkg::MAX_POINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sce_pkg::point_in_t               s_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sce_pkg::CFG_W-1:0]        cfg_data,
    output logic                             q_push,
    output sce_pkg::run_desc_t               q_data,
    input  logic                             q_full,
    input  logic                             store_free,
    input  logic                             rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
    output sce_pkg::point_t                  rd_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    sce_pkg::point_t mem [MAX_POINTS];
    sce_pkg::point_t rd_data_reg;

    logic [sce_pkg::CFG_W-1:0] slab_cfg_reg;
    logic                      busy_reg, busy_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    sce_pkg::coord_t           min_x_reg, min_x_next, max_x_reg, max_x_next;
    sce_pkg::coord_t           min_y_reg, min_y_next, max_y_reg, max_y_next;
    sce_pkg::coord_t           min_z_reg, min_z_next, max_z_reg, max_z_next;
    sce_pkg::point_t           left_reg, left_next, right_reg, right_next;
    sce_pkg::point_t           pt;
    logic                      accept;
    logic                      take;
    logic                      run_close;

    assign s_ready   = !busy_reg && !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign take      = accept && (count_reg != CNT_W'(MAX_POINTS));
    assign run_close = accept && s_data.final_point;
    assign pt        = '{x: s_data.px, y: s_data.py, z: s_data.pz};

    // Fold the beat into box, extremes and count
    always_comb begin
        count_next = count_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        min_z_next = min_z_reg;
        max_z_next = max_z_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (take) begin
            count_next = count_reg + 1'b1;
            if (pt.x < min_x_reg) min_x_next = pt.x;
            if (pt.x > max_x_reg) max_x_next = pt.x;
            if (pt.y < min_y_reg) min_y_next = pt.y;
            if (pt.y > max_y_reg) max_y_next = pt.y;
            if (pt.z < min_z_reg) min_z_next = pt.z;
            if (pt.z > max_z_reg) max_z_next = pt.z;
            if (pt.x < left_reg.x) left_next = pt;
            if (pt.x > right_reg.x) right_next = pt;
        end
    end

    // Hold the store until the back end has scanned it
    always_comb begin
        busy_next = busy_reg;
        if (run_close) begin
            busy_next = 1'b1;
        end else if (store_free) begin
            busy_next = 1'b0;
        end
    end

    // Build the descriptor from the values that include this beat
    always_comb begin
        q_push          = run_close;
        q_data.min_x    = min_x_next;
        q_data.max_x    = max_x_next;
        q_data.min_y    = min_y_next;
        q_data.max_y    = max_y_next;
        q_data.min_z    = min_z_next;
        q_data.max_z    = max_z_next;
        q_data.left     = left_next;
        q_data.right    = right_next;
        q_data.count    = sce_pkg::CNT_MAX_W'(count_next);
        q_data.slab_cfg = slab_cfg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || run_close) begin
            count_reg <= '0;
            min_x_reg <= sce_pkg::COORD_MAX;
            max_x_reg <= sce_pkg::COORD_MIN;
            min_y_reg <= sce_pkg::COORD_MAX;
            max_y_reg <= sce_pkg::COORD_MIN;
            min_z_reg <= sce_pkg::COORD_MAX;
            max_z_reg <= sce_pkg::COORD_MIN;
            left_reg  <= '{x: sce_pkg::COORD_MAX, y: '0, z: '0};
            right_reg <= '{x: sce_pkg::COORD_MIN, y: '0, z: '0};
        end else begin
            count_reg <= count_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            min_z_reg <= min_z_next;
            max_z_reg <= max_z_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            slab_cfg_reg <= sce_pkg::SLAB_CFG_RESET;
        end else begin
            busy_reg <= busy_next;
            if (cfg_valid) begin
                slab_cfg_reg <= cfg_data;
            end
        end
    end

    // Point store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (take) begin
            mem[count_reg[ADDR_W-1:0]] <= pt;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sce_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sce_back
// Run processor: slab edges, slab scan of the store, centroid division and
// result beats.
// ---------------------------------------------------------------------------
module sce_back #(
    parameter int MAX_POINTS = sce_pkg::MAX_POINTS_DEF,
    parameter int MAX_SLABS  = sce_pkg::MAX_SLABS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  sce_pkg::run_desc_t               q_data,
    output logic                             store_free,
    output logic                             rd_en,
    output logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
    input  sce_pkg::point_t                  rd_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sce_pkg::result_t                 m_data
);

    localparam int COORD_W = sce_pkg::COORD_W;
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SLAB_W  = $clog2(MAX_SLABS + 1);
    localparam int IDX_W   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int SUM_W   = COORD_W + CNT_W;
    localparam int PROD_W  = COORD_W + SLAB_W;
    localparam int DW      = sce_pkg::max_int(SUM_W, PROD_W);
    localparam int VW      = sce_pkg::max_int(CNT_W, SLAB_W);

    sce_pkg::back_state_t state_reg, state_next;
    sce_pkg::run_desc_t   desc_reg;

    logic [SLAB_W-1:0]        s_eff_reg;
    logic [COORD_W-1:0]       width_reg;
    logic [SLAB_W-1:0]        j_reg;
    sce_pkg::coord_t          edge_reg [MAX_SLABS + 1];
    logic [CNT_W-1:0]         scan_i_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [2:0][SUM_W-1:0]    sum_reg [MAX_SLABS];
    logic [CNT_W-1:0]         cnt_reg [MAX_SLABS];
    logic [SLAB_W-1:0]        slab_reg;
    logic [1:0]               coord_reg;
    sce_pkg::coord_t          cent_reg [3];
    logic                     m_valid_reg;
    sce_pkg::result_t         m_data_reg;

    logic                     out_free;
    logic                     out_load;
    sce_pkg::result_t         beat;
    logic                     scan_done;
    logic                     slab_end;
    logic [IDX_W-1:0]         slab_idx;
    logic                     div_start;
    logic [DW-1:0]            div_dividend;
    logic [VW-1:0]            div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [DW-1:0]            div_quot;
    logic [PROD_W-1:0]        edge_prod;
    logic signed [SUM_W-1:0]  cur_sum;
    logic [SUM_W-1:0]         cur_mag;
    logic [MAX_SLABS-1:0]     hit_vec;
    logic                     yz_in;
    logic [IDX_W-1:0]         hit_idx;
    logic [SLAB_W-1:0]        s_clamp;
    logic signed [COORD_W:0]  width_wide;
    logic signed [COORD_W:0]  edge_wide;
    sce_pkg::coord_t          quot_c;

    sce_divider #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = (scan_i_reg == CNT_W'(desc_reg.count));
    assign slab_end  = (slab_reg == s_eff_reg);
    assign slab_idx  = slab_reg[IDX_W-1:0];
    assign cur_sum   = sum_reg[slab_idx][coord_reg];
    assign cur_mag   = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    assign edge_prod = PROD_W'(j_reg) * PROD_W'(width_reg);
    assign quot_c    = div_quot[COORD_W-1:0];
    assign edge_wide = {desc_reg.min_x[COORD_W-1], desc_reg.min_x} + {1'b0, quot_c};

    // Clamp the slab setting and measure the box width from the queue head
    always_comb begin
        if (q_data.slab_cfg == '0) begin
            s_clamp = SLAB_W'(1);
        end else if (int'(q_data.slab_cfg) > MAX_SLABS) begin
            s_clamp = SLAB_W'(MAX_SLABS);
        end else begin
            s_clamp = SLAB_W'(q_data.slab_cfg);
        end
        width_wide = {q_data.max_x[COORD_W-1], q_data.max_x}
                   - {q_data.min_x[COORD_W-1], q_data.min_x};
    end

    // Classify the fetched point: Y/Z inside the box, then which slab
    always_comb begin
        yz_in = (rd_data.y > desc_reg.min_y) && (rd_data.y < desc_reg.max_y) &&
                (rd_data.z > desc_reg.min_z) && (rd_data.z < desc_reg.max_z);
        for (int s = 0; s < MAX_SLABS; s++) begin
            hit_vec[s] = (SLAB_W'(s) < s_eff_reg) &&
                         (rd_data.x > edge_reg[s]) && (rd_data.x < edge_reg[s + 1]);
        end
        hit_idx = '0;
        for (int s = MAX_SLABS - 1; s >= 0; s--) begin
            if (hit_vec[s]) hit_idx = IDX_W'(s);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sce_pkg::B_IDLE: begin
                if (!q_empty) state_next = sce_pkg::B_EDGE_START;
            end
            sce_pkg::B_EDGE_START: state_next = sce_pkg::B_EDGE_WAIT;
            sce_pkg::B_EDGE_WAIT: begin
                if (div_done) begin
                    state_next = (j_reg == s_eff_reg) ? sce_pkg::B_SCAN_RD
                                                      : sce_pkg::B_EDGE_START;
                end
            end
            sce_pkg::B_SCAN_RD: begin
                state_next = scan_done ? sce_pkg::B_EMIT_LEFT : sce_pkg::B_SCAN_WAIT;
            end
            sce_pkg::B_SCAN_WAIT: state_next = sce_pkg::B_SCAN_CLS;
            sce_pkg::B_SCAN_CLS:  state_next = sce_pkg::B_SCAN_ACC;
            sce_pkg::B_SCAN_ACC:  state_next = sce_pkg::B_SCAN_RD;
            sce_pkg::B_EMIT_LEFT: begin
                if (out_free) state_next = sce_pkg::B_SLAB_CHECK;
            end
            sce_pkg::B_SLAB_CHECK: begin
                if (slab_end) begin
                    state_next = sce_pkg::B_EMIT_RIGHT;
                end else if (cnt_reg[slab_idx] != '0) begin
                    state_next = sce_pkg::B_DIV_START;
                end
            end
            sce_pkg::B_DIV_START: state_next = sce_pkg::B_DIV_WAIT;
            sce_pkg::B_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (coord_reg == 2'd2) ? sce_pkg::B_EMIT_CENT
                                                     : sce_pkg::B_DIV_START;
                end
            end
            sce_pkg::B_EMIT_CENT: begin
                if (out_free) state_next = sce_pkg::B_SLAB_CHECK;
            end
            sce_pkg::B_EMIT_RIGHT: begin
                if (out_free) state_next = sce_pkg::B_IDLE;
            end
            default: state_next = sce_pkg::B_IDLE;
        endcase
    end

    // Control outputs and the beat to present
    always_comb begin
        q_pop        = 1'b0;
        store_free   = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = scan_i_reg[ADDR_W-1:0];
        div_start    = 1'b0;
        div_dividend = DW'(edge_prod);
        div_divisor  = VW'(s_eff_reg);
        out_load     = 1'b0;
        beat         = '{lx: desc_reg.left.x, ly: desc_reg.left.y,
                         lz: desc_reg.left.z, run_end: 1'b0};
        unique case (state_reg)
            sce_pkg::B_IDLE:       q_pop = !q_empty;
            sce_pkg::B_EDGE_START: div_start = 1'b1;
            sce_pkg::B_SCAN_RD: begin
                store_free = scan_done;
                rd_en      = !scan_done;
            end
            sce_pkg::B_EMIT_LEFT:  out_load = out_free;
            sce_pkg::B_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = DW'(cur_mag);
                div_divisor  = VW'(cnt_reg[slab_idx]);
            end
            sce_pkg::B_EMIT_CENT: begin
                out_load = out_free;
                beat     = '{lx: cent_reg[0], ly: cent_reg[1],
                             lz: cent_reg[2], run_end: 1'b0};
            end
            sce_pkg::B_EMIT_RIGHT: begin
                out_load = out_free;
                beat     = '{lx: desc_reg.right.x, ly: desc_reg.right.y,
                             lz: desc_reg.right.z, run_end: 1'b1};
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sce_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= beat;
        end
        case (state_reg)
            sce_pkg::B_IDLE: begin
                // Latch the run and clear the slab accumulators
                if (!q_empty) begin
                    desc_reg    <= q_data;
                    s_eff_reg   <= s_clamp;
                    width_reg   <= width_wide[COORD_W] ? '0 : width_wide[COORD_W-1:0];
                    edge_reg[0] <= q_data.min_x;
                    j_reg       <= SLAB_W'(1);
                    scan_i_reg  <= '0;
                    slab_reg    <= '0;
                    for (int s = 0; s < MAX_SLABS; s++) begin
                        cnt_reg[s] <= '0;
                        sum_reg[s] <= '0;
                    end
                end
            end
            sce_pkg::B_EDGE_WAIT: begin
                if (div_done) begin
                    edge_reg[j_reg] <= edge_wide[COORD_W-1:0];
                    j_reg           <= j_reg + 1'b1;
                end
            end
            sce_pkg::B_SCAN_CLS: begin
                hit_reg <= yz_in && (|hit_vec);
                idx_reg <= hit_idx;
            end
            sce_pkg::B_SCAN_ACC: begin
                // Add the point into its slab
                if (hit_reg) begin
                    sum_reg[idx_reg][0] <= sum_reg[idx_reg][0] + SUM_W'(rd_data.x);
                    sum_reg[idx_reg][1] <= sum_reg[idx_reg][1] + SUM_W'(rd_data.y);
                    sum_reg[idx_reg][2] <= sum_reg[idx_reg][2] + SUM_W'(rd_data.z);
                    cnt_reg[idx_reg]    <= cnt_reg[idx_reg] + 1'b1;
                end
                scan_i_reg <= scan_i_reg + 1'b1;
            end
            sce_pkg::B_SLAB_CHECK: begin
                coord_reg <= 2'd0;
                if (!slab_end && cnt_reg[slab_idx] == '0) begin
                    slab_reg <= slab_reg + 1'b1;
                end
            end
            sce_pkg::B_DIV_WAIT: begin
                // Restore the sign: truncation toward zero
                if (div_done) begin
                    cent_reg[coord_reg] <= cur_sum[SUM_W-1] ? -quot_c : quot_c;
                    coord_reg           <= coord_reg + 2'd1;
                end
            end
            sce_pkg::B_EMIT_CENT: begin
                if (out_free) slab_reg <= slab_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sce_pkg::B_IDLE) |-> (scan_i_reg <= CNT_W'(desc_reg.count)))
        else $error("scan index ran past the point count");

    a_edge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sce_pkg::B_EDGE_START) |-> (j_reg != '0 && j_reg <= s_eff_reg))
        else $error("slab edge index out of range");

    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && state_reg == sce_pkg::B_EMIT_RIGHT) |=> (m_valid && m_data.run_end))
        else $error("closing beat lost its run end flag");

    a_pop_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == sce_pkg::B_EDGE_START))
        else $error("descriptor popped without starting a run");
`endif

endmodule

// ----- rtl/core/slab_centroid_extremes.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slab_centroid_extremes
// Loads 3-D points, then emits the leftmost point, the centroid of each
// non-empty X slab of the bounding box, and the rightmost point.
// ---------------------------------------------------------------------------
//  channel   ports                            beat
//  input     s_valid / s_ready / s_data      one point, final_point ends set
//  result    m_valid / m_ready / m_data      one point, run_end on the last
//  config    cfg_valid / cfg_ready / cfg_data slab count (always ready)
//
//  Loading takes one point per cycle until the final point is accepted.
//  Then s_ready stays low through the slab edges (S divisions of a DW-bit
//  dividend, DW = 32 + clog2(MAX_POINTS+1) for defaults) and the store scan
//  (read, wait, classify, accumulate per point; one store read port);
//  results follow at one divider run per coordinate, three per non-empty slab.
//  Reset is synchronous on aresetn, no clearing pass; a stalled m_ready
//  holds the back end while loading of the next set resumes after the scan.
// ---------------------------------------------------------------------------
module slab_centroid_extremes #(
    parameter int MAX_POINTS = sce_pkg::MAX_POINTS_DEF,
    parameter int MAX_SLABS  = sce_pkg::MAX_SLABS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sce_pkg::point_in_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sce_pkg::result_t          m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sce_pkg::CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    sce_pkg::run_desc_t  q_push_data;
    sce_pkg::run_desc_t  q_pop_data;
    logic                store_free;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    sce_pkg::point_t     rd_data;

    sce_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .q_full     (q_full),
        .store_free (store_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    sce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    sce_back #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_SLABS  (MAX_SLABS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_pop_data),
        .store_free (store_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
